@@ src/vsm_pkg.sv @@
// Shared declarations for the versioned snapshot memory.
// Holds the op and status codes, default sizes and the address width helper.
// Depends on nothing; every other file imports it.
package vsm_pkg;

  localparam int ARRAY_LENGTH_DEF = 1024;
  localparam int MAX_VERSIONS_DEF = 16;
  localparam int SNAP_ID_BITS_DEF = 16;
  localparam int DATA_W           = 32;
  localparam int OP_W             = 2;
  localparam int STATUS_W         = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SET  = 2'd0,
    OP_SNAP = 2'd1,
    OP_GET  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EXHAUSTED = 2'd2
  } status_e;

  // Number of address bits for a memory of n entries, never below one.
  function automatic int addr_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

@@ src/versioned_snapshot_memory.sv @@
// Top level of the versioned snapshot memory: sequencer, search unit and stores.
// Depends on vsm_pkg and instantiates vsm_ram for the count and version stores.
//
//   channel | direction | handshake                  | fields
//   --------+-----------+----------------------------+---------------------------------
//   in      | input     | in_valid_i / in_stall_o    | op_i, index_i, value_i, snap_id_i
//   out     | output    | out_valid_o / out_stall_i  | read_value_o, snap_taken_o, status_o
//
// After reset a clearing pass zeroes the per-element version counts, one entry
// a cycle, so the block accepts no item until that pass is through.
// One item is handled at a time. A snap, an unused op or an out-of-range element goes
// straight to the finishing step; a set reads the count and, if any, the newest version,
// then writes; a get reads the count, then runs at most ceil(log2(MAX_VERSIONS + 1))
// binary search probes, each one read of the version store. A finished result sits in
// the output register; a stall while it is full holds the finishing step and the input.
module versioned_snapshot_memory #(
  parameter int ARRAY_LENGTH = vsm_pkg::ARRAY_LENGTH_DEF,
  parameter int MAX_VERSIONS = vsm_pkg::MAX_VERSIONS_DEF,
  parameter int SNAP_ID_BITS = vsm_pkg::SNAP_ID_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_stall_o,
  input  logic [vsm_pkg::OP_W-1:0]                    op_i,
  input  logic [vsm_pkg::addr_bits(ARRAY_LENGTH)-1:0] index_i,
  input  logic signed [vsm_pkg::DATA_W-1:0]           value_i,
  input  logic [SNAP_ID_BITS-1:0]                     snap_id_i,
  output logic                                        out_valid_o,
  input  logic                                        out_stall_i,
  output logic signed [vsm_pkg::DATA_W-1:0]           read_value_o,
  output logic [SNAP_ID_BITS-1:0]                     snap_taken_o,
  output logic [vsm_pkg::STATUS_W-1:0]                status_o
);
  import vsm_pkg::*;

  localparam int IdxW       = addr_bits(ARRAY_LENGTH);
  localparam int StoreDepth = ARRAY_LENGTH * MAX_VERSIONS;
  localparam int AddrW      = addr_bits(StoreDepth);
  localparam int CntW       = $clog2(MAX_VERSIONS + 1);
  localparam int WordW      = SNAP_ID_BITS + DATA_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CNT,
    S_LAST,
    S_PROBE,
    S_DONE
  } state_e;

  // Sequencer state and per-item registers.
  state_e                     state_q, state_d;
  logic [IdxW-1:0]            clr_q, clr_d;
  logic [SNAP_ID_BITS-1:0]    open_q, open_d;
  logic [OP_W-1:0]            op_q, op_d;
  logic [IdxW-1:0]            idx_q, idx_d;
  logic signed [DATA_W-1:0]   val_q, val_d;
  logic [SNAP_ID_BITS-1:0]    sid_q, sid_d;
  logic [AddrW-1:0]           base_q, base_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [CntW-1:0]            lo_q, lo_d;
  logic [CntW-1:0]            hi_q, hi_d;
  logic [CntW-1:0]            mid_q, mid_d;
  logic signed [DATA_W-1:0]   rv_q, rv_d;
  logic [SNAP_ID_BITS-1:0]    taken_q, taken_d;
  logic [STATUS_W-1:0]        stat_q, stat_d;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0]   out_rv_q, out_rv_d;
  logic [SNAP_ID_BITS-1:0]    out_taken_q, out_taken_d;
  logic [STATUS_W-1:0]        out_stat_q, out_stat_d;

  // Memory ports.
  logic                       cnt_we, cnt_re;
  logic [IdxW-1:0]            cnt_waddr, cnt_raddr;
  logic [CntW-1:0]            cnt_wdata, cnt_rd;
  logic                       st_we, st_re;
  logic [AddrW-1:0]           st_waddr, st_raddr;
  logic [WordW-1:0]           st_wdata, st_rd;
  logic [SNAP_ID_BITS-1:0]    rd_id;
  logic signed [DATA_W-1:0]   rd_val;

  // Search step: the one compare unit and the next bounds of the binary search.
  logic                       hit;
  logic [CntW-1:0]            nlo, nhi, nmid;
  logic                       in_range;
  logic                       in_accept;

  assign rd_id  = st_rd[WordW-1:DATA_W];
  assign rd_val = st_rd[DATA_W-1:0];
  assign hit    = (rd_id <= sid_q);
  assign nlo    = hit ? (mid_q + CntW'(1)) : lo_q;
  assign nhi    = hit ? hi_q : mid_q;
  assign nmid   = nlo + ((nhi - nlo) >> 1);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_range   = (32'(index_i) < 32'(ARRAY_LENGTH));

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    open_d      = open_q;
    op_d        = op_q;
    idx_d       = idx_q;
    val_d       = val_q;
    sid_d       = sid_q;
    base_d      = base_q;
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    rv_d        = rv_q;
    taken_d     = taken_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rv_d    = out_rv_q;
    out_taken_d = out_taken_q;
    out_stat_d  = out_stat_q;

    cnt_we    = 1'b0;
    cnt_waddr = idx_q;
    cnt_wdata = '0;
    cnt_re    = 1'b0;
    cnt_raddr = index_i;
    st_we     = 1'b0;
    st_waddr  = base_q;
    st_wdata  = {open_q, val_q};
    st_re     = 1'b0;
    st_raddr  = base_q;

    unique case (state_q)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        clr_d     = clr_q + IdxW'(1);
        if (clr_q == IdxW'(ARRAY_LENGTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          op_d    = op_i;
          idx_d   = index_i;
          val_d   = value_i;
          sid_d   = snap_id_i;
          base_d  = AddrW'(AddrW'(index_i) * AddrW'(MAX_VERSIONS));
          rv_d    = '0;
          taken_d = '0;
          stat_d  = STAT_OK;
          state_d = S_DONE;
          case (op_i)
            OP_SET, OP_GET: begin
              // Out-of-range elements answer zero without touching the stores.
              if (in_range) begin
                cnt_re  = 1'b1;
                state_d = S_CNT;
              end
            end
            OP_SNAP: begin
              if (&open_q) begin
                stat_d = STAT_EXHAUSTED;
              end else begin
                taken_d = open_q;
                open_d  = open_q + SNAP_ID_BITS'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_CNT: begin
        cnt_d = cnt_rd;
        if (op_q == OP_SET) begin
          if (cnt_rd != '0) begin
            // Look at the newest version to see whether this is an overwrite.
            st_re    = 1'b1;
            st_raddr = base_q + AddrW'(cnt_rd) - AddrW'(1);
            state_d  = S_LAST;
          end else begin
            st_we     = 1'b1;
            st_waddr  = base_q;
            cnt_we    = 1'b1;
            cnt_wdata = CntW'(1);
            state_d   = S_DONE;
          end
        end else begin
          // Start the search for the last version with an id at or below sid.
          lo_d  = '0;
          hi_d  = cnt_rd;
          mid_d = cnt_rd >> 1;
          if (cnt_rd != '0) begin
            st_re    = 1'b1;
            st_raddr = base_q + AddrW'(cnt_rd >> 1);
            state_d  = S_PROBE;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_LAST: begin
        state_d = S_DONE;
        if (rd_id == open_q) begin
          st_we    = 1'b1;
          st_waddr = base_q + AddrW'(cnt_q) - AddrW'(1);
        end else if (32'(cnt_q) >= 32'(MAX_VERSIONS)) begin
          stat_d = STAT_FULL;
        end else begin
          st_we     = 1'b1;
          st_waddr  = base_q + AddrW'(cnt_q);
          cnt_we    = 1'b1;
          cnt_wdata = cnt_q + CntW'(1);
        end
      end

      S_PROBE: begin
        // A hit moves the low bound up; the last hit is the newest match.
        if (hit) begin
          rv_d = rd_val;
        end
        lo_d  = nlo;
        hi_d  = nhi;
        mid_d = nmid;
        if (nlo < nhi) begin
          st_re    = 1'b1;
          st_raddr = base_q + AddrW'(nmid);
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_rv_d    = rv_q;
          out_taken_d = taken_q;
          out_stat_d  = stat_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      open_q      <= '0;
      op_q        <= '0;
      idx_q       <= '0;
      val_q       <= '0;
      sid_q       <= '0;
      base_q      <= '0;
      cnt_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      rv_q        <= '0;
      taken_q     <= '0;
      stat_q      <= '0;
      out_valid_q <= 1'b0;
      out_rv_q    <= '0;
      out_taken_q <= '0;
      out_stat_q  <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      open_q      <= open_d;
      op_q        <= op_d;
      idx_q       <= idx_d;
      val_q       <= val_d;
      sid_q       <= sid_d;
      base_q      <= base_d;
      cnt_q       <= cnt_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      mid_q       <= mid_d;
      rv_q        <= rv_d;
      taken_q     <= taken_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
      out_rv_q    <= out_rv_d;
      out_taken_q <= out_taken_d;
      out_stat_q  <= out_stat_d;
    end
  end

  // Number of versions held by each element.
  vsm_ram #(
    .Width (CntW),
    .Depth (ARRAY_LENGTH)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rd)
  );

  // Version list of each element, id and value side by side.
  vsm_ram #(
    .Width (WordW),
    .Depth (StoreDepth)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rd)
  );

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_rv_q;
  assign snap_taken_o = out_taken_q;
  assign status_o     = out_stat_q;

endmodule

@@ src/vsm_ram.sv @@
// Simple dual-port RAM: one write port and one read port with registered data.
// Depends on vsm_pkg for the address width helper.
module vsm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [vsm_pkg::addr_bits(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [vsm_pkg::addr_bits(Depth)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);
  import vsm_pkg::*;

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/tb_versioned_snapshot_memory.sv @@
// Self-checking testbench for versioned_snapshot_memory at its default sizes.
// Imports vsm_pkg for codes and widths and needs nothing else besides the RTL;
// a queue-fed driver, a result monitor and an in-bench history model do the work.
module tb_versioned_snapshot_memory;
  timeunit 1ns;
  timeprecision 1ps;

  import vsm_pkg::*;

  // The block is used at its default sizes, so the bench mirrors them here.
  localparam int ELEMS = ARRAY_LENGTH_DEF;
  localparam int DEPTH = MAX_VERSIONS_DEF;
  localparam int SID_W = SNAP_ID_BITS_DEF;
  localparam int IDX_W = addr_bits(ARRAY_LENGTH_DEF);
  localparam int SID_LAST = (1 << SID_W) - 1;

  // Code 3 has no name in the package; the block must answer it with all zero.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1150;
  localparam int BURST_SPACING = 280;
  localparam int QUIET_FROM = 4000;
  localparam int QUIET_TO = 8000;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 100_000;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] value;
    logic [SID_W-1:0]  snap_id;
  } request_t;

  typedef struct packed {
    logic [DATA_W-1:0]   read_value;
    logic [SID_W-1:0]    snap_taken;
    logic [STATUS_W-1:0] status;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Input channel. The payload ports follow the held request register, which
  // only changes at a rising edge after acceptance or while the channel is empty.
  logic     feed_valid = 1'b0;
  request_t held_req = '0;
  logic     in_stall_o;

  logic                     out_valid_o;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] read_value_o;
  logic [SID_W-1:0]         snap_taken_o;
  logic [STATUS_W-1:0]      status_o;

  request_t queued_ops[$];
  answer_t  expected_answers[$];

  int cycle_count = 0;
  int faults = 0;
  int n_checked = 0;
  int n_sets = 0;
  int n_snaps = 0;
  int n_gets = 0;
  int n_unused = 0;
  int n_full = 0;
  int n_exhausted = 0;

  // Bench copy of the block's state: per element, a list of (snapshot id,
  // value) pairs kept in ascending id order, its length, and the open id.
  logic [SID_W-1:0]  hist_id[ELEMS][DEPTH];
  logic [DATA_W-1:0] hist_val[ELEMS][DEPTH];
  int unsigned       hist_len[ELEMS] = '{default: 0};
  logic [SID_W-1:0]  open_id = '0;

  // Stimulus-side bookkeeping: the open id that the queued snaps will reach,
  // which elements have been written, and the pools of frequently used elements.
  int               open_est = 0;
  bit               touched[ELEMS];
  logic [IDX_W-1:0] hot_idx[4];
  logic [IDX_W-1:0] warm_idx[16];

  // Both sides idle now and then, except in one quiet window of the run.
  wire noisy = (cycle_count < QUIET_FROM) || (cycle_count >= QUIET_TO);

  versioned_snapshot_memory dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (feed_valid),
    .in_stall_o  (in_stall_o),
    .op_i        (held_req.op),
    .index_i     (held_req.index),
    .value_i     (held_req.value),
    .snap_id_i   (held_req.snap_id),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .read_value_o(read_value_o),
    .snap_taken_o(snap_taken_o),
    .status_o    (status_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Newest value of an element recorded at or before the queried id. The ids in
  // a list rise strictly, so the first match from the top is the one wanted.
  function automatic logic [DATA_W-1:0] value_as_of(input logic [IDX_W-1:0] idx,
                                                    input logic [SID_W-1:0] sid);
    for (int k = int'(hist_len[idx]) - 1; k >= 0; k--) begin
      if (hist_id[idx][k] <= sid) return hist_val[idx][k];
    end
    return '0;
  endfunction

  // Applies one accepted item to the history and returns the answer it causes.
  function automatic answer_t replay_on_history(input request_t req);
    answer_t     ans;
    int unsigned len;
    ans = '0;
    len = hist_len[req.index];
    case (req.op)
      OP_SET: begin
        n_sets++;
        if (len > 0 && hist_id[req.index][len-1] == open_id) begin
          // A second write within the open snapshot replaces that version,
          // even when the list is already full.
          hist_val[req.index][len-1] = req.value;
        end else if (len >= DEPTH) begin
          ans.status = STAT_FULL;
          n_full++;
        end else begin
          hist_id[req.index][len] = open_id;
          hist_val[req.index][len] = req.value;
          hist_len[req.index] = len + 1;
        end
      end
      OP_SNAP: begin
        n_snaps++;
        if (open_id == SID_LAST) begin
          // The id counter has saturated: nothing moves, the snap is refused.
          ans.status = STAT_EXHAUSTED;
          n_exhausted++;
        end else begin
          ans.snap_taken = open_id;
          open_id = open_id + 1'b1;
        end
      end
      OP_GET: begin
        n_gets++;
        ans.read_value = value_as_of(req.index, req.snap_id);
      end
      default: begin
        n_unused++;
      end
    endcase
    return ans;
  endfunction

  // Queues one item; the narrow fields take the low bits of what is passed.
  task automatic push_request(input int op, input int idx,
                              input logic [DATA_W-1:0] val, input int sid);
    request_t req;
    req.op = OP_W'(op);
    req.index = IDX_W'(idx);
    req.value = val;
    req.snap_id = SID_W'(sid);
    queued_ops = {queued_ops, req};
    if (req.op == OP_SNAP && open_est < SID_LAST) open_est++;
    if (req.op == OP_SET) touched[req.index] = 1'b1;
  endtask

  // Mostly the small hot and warm pools, so that version lists fill up and
  // searches run over long lists; the rest spreads over the whole array.
  function automatic logic [IDX_W-1:0] random_index();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return hot_idx[$urandom_range(0, 3)];
    if (p < 75) return warm_idx[$urandom_range(0, 15)];
    return IDX_W'($urandom_range(0, ELEMS - 1));
  endfunction

  function automatic logic [DATA_W-1:0] random_value();
    int p;
    p = $urandom_range(0, 99);
    case (p)
      0, 1, 2: return 32'h7fff_ffff;
      3, 4, 5: return 32'h8000_0000;
      6, 7, 8: return 32'hffff_ffff;
      9, 10, 11: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Queried ids cluster around the ids actually in use, with some very small
  // ones that can fall below every version and some anywhere in the id space.
  function automatic logic [SID_W-1:0] random_sid();
    int p;
    int top;
    p = $urandom_range(0, 99);
    top = (open_est + 1 > SID_LAST) ? SID_LAST : open_est + 1;
    if (p < 50) return SID_W'($urandom_range(0, top));
    if (p < 70) return SID_W'($urandom_range(0, 3));
    return SID_W'($urandom_range(0, SID_LAST));
  endfunction

  // Driver. An accepted item is replayed on the history at the edge that takes
  // it, and the next queued item (if the sender is not idling) goes up in the
  // same block, so valid is written at most once per edge.
  always @(posedge clk_i or negedge rst_ni) begin
    request_t nxt;
    answer_t  due;
    if (!rst_ni) begin
      feed_valid <= 1'b0;
      held_req <= '0;
    end else begin
      if (feed_valid && !in_stall_o) begin
        due = replay_on_history(held_req);
        expected_answers = {expected_answers, due};
      end
      if (!feed_valid || !in_stall_o) begin
        if (queued_ops.size() != 0 && !(noisy && $urandom_range(0, 99) < 8)) begin
          nxt = queued_ops.pop_front();
          held_req <= nxt;
          feed_valid <= 1'b1;
        end else begin
          feed_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Results arrive in item order, one per item, so each accepted
  // result is matched against the oldest answer still outstanding.
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_answers.size() == 0) begin
          $error("result with nothing outstanding: read_value %0d snap_taken %0d status %0d",
                 read_value_o, snap_taken_o, status_o);
          faults++;
        end else begin
          want = expected_answers.pop_front();
          n_checked++;
          if (read_value_o !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", $signed(want.read_value), read_value_o);
            faults++;
          end
          if (snap_taken_o !== want.snap_taken) begin
            $error("snap_taken: expected %0d, got %0d", want.snap_taken, snap_taken_o);
            faults++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            faults++;
          end
        end
      end
      out_stall <= noisy && ($urandom_range(0, 99) < 8);
    end
  end

  // Watchdog on total run length; the clearing pass after reset is included.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d answers outstanding",
               cycle_count, expected_answers.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int               made;
    int               next_burst;
    int               p;
    logic [IDX_W-1:0] fresh;

    for (int i = 0; i < 4; i++) hot_idx[i] = IDX_W'($urandom_range(1, ELEMS - 2));
    for (int i = 0; i < 16; i++) warm_idx[i] = IDX_W'($urandom_range(0, ELEMS - 1));

    // Directed opening. Element 0 and the last element carry the extreme values,
    // and the first snapshot is taken with both already written.
    push_request(OP_GET, 0, 0, 0);                      // never written
    push_request(OP_UNUSED, '1, '1, '1);                // unused code, all fields high
    push_request(OP_SET, ELEMS - 1, 32'h7fff_ffff, '1);
    push_request(OP_SET, 0, 32'h8000_0000, 0);
    push_request(OP_SET, 0, 32'hffff_ffff, 0);          // overwrite in the open snapshot
    push_request(OP_GET, 0, 0, 0);                      // query of the open snapshot
    push_request(OP_GET, ELEMS - 1, 0, '1);
    push_request(OP_SNAP, 0, 0, 0);                     // closes id 0
    push_request(OP_SET, 0, 32'd5, 0);
    push_request(OP_SET, ELEMS - 1, 32'h0000_0000, 0);
    push_request(OP_SNAP, 0, 0, 0);                     // closes id 1
    push_request(OP_GET, 0, 0, 0);
    push_request(OP_GET, 0, 0, 1);
    push_request(OP_GET, 0, 0, '1);
    push_request(OP_GET, ELEMS - 1, 0, 0);
    push_request(OP_GET, ELEMS - 1, 0, 1);
    push_request(OP_SET, 512, 32'h5555_5555, '0);
    push_request(OP_SET, 341, 32'haaaa_aaaa, 16'haaaa);
    push_request(OP_GET, 512, 0, 16'h5555);
    push_request(OP_GET, 341, 0, 0);                    // written under a later id
    push_request(OP_GET, 682, 0, 2);                    // never written

    // Random part. Now and then a fresh element is driven through a full list:
    // sixteen versions in sixteen snapshots, an overwrite while full, then a
    // new-snapshot write that must be refused.
    made = 0;
    next_burst = BURST_SPACING / 2;
    while (made < RANDOM_ITEMS) begin
      if (made >= next_burst) begin
        do fresh = IDX_W'($urandom_range(0, ELEMS - 1)); while (touched[fresh]);
        repeat (DEPTH) begin
          push_request(OP_SNAP, random_index(), random_value(), random_sid());
          push_request(OP_SET, fresh, random_value(), random_sid());
        end
        push_request(OP_SET, fresh, random_value(), 0);
        push_request(OP_GET, fresh, 0, open_est);
        push_request(OP_SNAP, 0, 0, 0);
        push_request(OP_SET, fresh, random_value(), 0);
        push_request(OP_GET, fresh, 0, $urandom_range(0, open_est));
        made += 2 * DEPTH + 5;
        next_burst += BURST_SPACING;
      end
      p = $urandom_range(0, 99);
      if (p < 35) push_request(OP_SET, random_index(), random_value(), $urandom);
      else if (p < 55) push_request(OP_SNAP, $urandom, $urandom, $urandom);
      else if (p < 95) push_request(OP_GET, random_index(), $urandom, random_sid());
      else push_request(OP_UNUSED, $urandom, $urandom, $urandom);
      made++;
    end

    // A short tail: a few more snaps, a write, reads at the top of the id space
    // that must still find the newest versions, and a read at id zero.
    repeat (3) push_request(OP_SNAP, 0, 0, 0);
    push_request(OP_SET, hot_idx[0], random_value(), 0);
    push_request(OP_GET, hot_idx[0], 0, SID_LAST);
    push_request(OP_GET, hot_idx[1], 0, SID_LAST - 1);
    push_request(OP_GET, warm_idx[0], 0, 0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (queued_ops.size() != 0 || feed_valid || expected_answers.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Checked %0d results: %0d sets, %0d snaps, %0d gets, %0d unused codes.",
             n_checked, n_sets, n_snaps, n_gets, n_unused);
    $display("%0d sets hit a full version list, %0d snaps found the ids used up.",
             n_full, n_exhausted);
    if (faults == 0 && expected_answers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
